/* rtl/bpsm_pkg.sv */
package bpsm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 44;
    localparam int CNT_W    = 17;
    localparam int Q_W      = 60;
    localparam int LOG_W    = 30;
    localparam int FRAC_W   = 24;

    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [29:0]      DB_K      = 30'd808071242;
    localparam logic [30:0]      PDB_OFF   = 31'd46 << FRAC_W;
    localparam logic [15:0]      DB_MIN    = 16'h8000;
    localparam logic [15:0]      DB_MAX    = 16'h7fff;
    localparam logic [15:0]      NOISE_RST = 16'd8;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
        logic                       meas;
        logic [SUM_W-1:0]           sum;
        logic [CNT_W-1:0]           cnt;
    } t_entry;

    typedef struct packed {
        logic signed [15:0] sample_out_i;
        logic signed [15:0] sample_out_q;
        logic               measure_valid;
        logic signed [15:0] power_db;
        logic signed [15:0] snr_db;
        logic               snr_invalid;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOGI,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_CHK,
        ST_DB_MUL,
        ST_DB_RND,
        ST_DONE
    } t_state;

endpackage

/* rtl/bpsm_front.sv */
module bpsm_front
    import bpsm_pkg::*;
#(
    parameter int MAX_WINDOW = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic signed [SAMPLE_W-1:0] i_sample_i,
    input  logic signed [SAMPLE_W-1:0] i_sample_q,
    input  logic                       i_last,
    output t_entry                     o_entry
);

    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [31:0]      p;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] sum_acc;
    logic [CW-1:0]    cnt_acc;
    logic             room;

    always_comb begin
        p       = 32'(i_sample_i * i_sample_i) + 32'(i_sample_q * i_sample_q);
        room    = r_cnt < CW'(MAX_WINDOW);
        sum_ext = {1'b0, r_sum} + (SUM_W+1)'(p);
        if (room) begin
            sum_acc = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            cnt_acc = r_cnt + CW'(1);
        end else begin
            sum_acc = r_sum;
            cnt_acc = r_cnt;
        end
        o_entry.si   = i_sample_i;
        o_entry.sq   = i_sample_q;
        o_entry.meas = i_last && (cnt_acc >= CW'(2));
        o_entry.sum  = sum_acc;
        o_entry.cnt  = CNT_W'(cnt_acc);
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (i_accept) begin
            n_sum = i_last ? '0 : sum_acc;
            n_cnt = i_last ? '0 : cnt_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/bpsm_fifo.sv */
module bpsm_fifo
    import bpsm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_data,
    output logic   o_empty
);

    t_entry     r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 2'd1;
            if (do_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
    end

endmodule

/* rtl/bpsm_back.sv */
module bpsm_back
    import bpsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_entry,
    input  logic        i_empty,
    output logic        o_pop,
    input  logic [15:0] i_noise,
    output t_result     o_result,
    output logic        o_empty,
    input  logic        i_pop
);

    t_state              r_state, n_state;
    t_entry              r_ent;
    logic [CNT_W:0]      r_rem;
    logic [Q_W-1:0]      r_quo;
    logic [5:0]          r_bit;
    logic [Q_W-1:0]      r_x;
    logic [5:0]          r_e;
    logic [30:0]         r_m;
    logic [61:0]         r_prod;
    logic [FRAC_W-1:0]   r_frac;
    logic [4:0]          r_step;
    logic [1:0]          r_sel;
    logic [LOG_W-1:0]    r_log [3];
    logic                r_dsel;
    logic [60:0]         r_dprod;
    logic                r_neg;
    logic [15:0]         r_pdb, r_sdb;
    t_result             r_out;
    logic                r_full;

    logic                slot_free;
    logic                load_pass, load_meas;
    logic [CNT_W:0]      trial;
    logic [31:0]         noise_q;
    logic [Q_W-1:0]      log_in;
    logic [31:0]         sq;
    logic [30:0]         m_next;
    logic [FRAC_W-1:0]   frac_next;
    logic signed [30:0]  d;
    logic [30:0]         mag;
    logic [60:0]         rnd;
    logic [16:0]         r_db;
    logic [15:0]         db_val;
    logic                q_zero, q_low, n_zero;

    assign slot_free = !r_full || i_pop;
    assign o_result  = r_out;
    assign o_empty   = !r_full;
    assign noise_q   = {i_noise, 16'd0};
    assign q_zero    = r_quo == '0;
    assign q_low     = r_quo <= Q_W'(noise_q);
    assign n_zero    = i_noise == 16'd0;

    always_comb begin
        trial = {r_rem[CNT_W-1:0], r_quo[Q_W-1]};
        case (r_sel)
            2'd0:    log_in = r_quo;
            2'd1:    log_in = r_quo - Q_W'(noise_q);
            default: log_in = Q_W'(noise_q);
        endcase
        if (log_in == '0) log_in = Q_W'(1);
        sq = r_prod[61:30];
        if (sq[31]) begin
            m_next    = sq[31:1];
            frac_next = {r_frac[FRAC_W-2:0], 1'b1};
        end else begin
            m_next    = sq[30:0];
            frac_next = {r_frac[FRAC_W-2:0], 1'b0};
        end
        if (!r_dsel) d = $signed({1'b0, r_log[0]}) - $signed(PDB_OFF);
        else         d = $signed({1'b0, r_log[1]}) - $signed({1'b0, r_log[2]});
        mag  = d[30] ? 31'(-d) : 31'(d);
        rnd  = r_dprod + (61'd1 << 43);
        r_db = rnd[60:44];
        if (r_neg) db_val = (r_db > 17'd32768) ? DB_MIN : 16'(17'd0 - r_db);
        else       db_val = (r_db > 17'd32767) ? DB_MAX : r_db[15:0];
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        load_pass = 1'b0;
        load_meas = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_entry.meas) begin
                        o_pop   = 1'b1;
                        n_state = ST_DIV;
                    end else if (slot_free) begin
                        o_pop     = 1'b1;
                        load_pass = 1'b1;
                    end
                end
            end
            ST_DIV:    if (r_bit == 6'(Q_W - 1)) n_state = ST_LOGI;
            ST_LOGI:   n_state = ST_NORM;
            ST_NORM:   if (r_x[Q_W-1]) n_state = ST_SQ_MUL;
            ST_SQ_MUL: n_state = ST_SQ_CHK;
            ST_SQ_CHK: begin
                if (r_step == 5'(FRAC_W - 1))
                    n_state = (r_sel == 2'd2) ? ST_DB_MUL : ST_LOGI;
                else
                    n_state = ST_SQ_MUL;
            end
            ST_DB_MUL: n_state = ST_DB_RND;
            ST_DB_RND: n_state = r_dsel ? ST_DONE : ST_DB_MUL;
            ST_DONE: begin
                if (slot_free) begin
                    load_meas = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_pass || load_meas) r_full <= 1'b1;
            else if (i_pop)             r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ent <= i_entry;
                r_rem <= '0;
                r_quo <= {i_entry.sum, 16'd0};
                r_bit <= '0;
                r_sel <= 2'd0;
            end
            // restoring division, one quotient bit a cycle
            ST_DIV: begin
                r_bit <= r_bit + 6'd1;
                if (trial >= {1'b0, r_ent.cnt}) begin
                    r_rem <= trial - {1'b0, r_ent.cnt};
                    r_quo <= {r_quo[Q_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[Q_W-2:0], 1'b0};
                end
            end
            ST_LOGI: begin
                r_x <= log_in;
                r_e <= 6'(Q_W - 1);
            end
            ST_NORM: begin
                if (r_x[Q_W-1]) begin
                    r_m    <= r_x[Q_W-1:Q_W-31];
                    r_step <= '0;
                    r_frac <= '0;
                end else begin
                    r_x <= {r_x[Q_W-2:0], 1'b0};
                    r_e <= r_e - 6'd1;
                end
            end
            ST_SQ_MUL: r_prod <= r_m * r_m;
            ST_SQ_CHK: begin
                r_m    <= m_next;
                r_frac <= frac_next;
                r_step <= r_step + 5'd1;
                if (r_step == 5'(FRAC_W - 1)) begin
                    r_log[r_sel] <= {r_e, frac_next};
                    r_sel        <= r_sel + 2'd1;
                    r_dsel       <= 1'b0;
                end
            end
            ST_DB_MUL: begin
                r_dprod <= mag * DB_K;
                r_neg   <= d[30];
            end
            ST_DB_RND: begin
                if (r_dsel) r_sdb <= db_val;
                else        r_pdb <= db_val;
                r_dsel <= 1'b1;
            end
            default: ;
        endcase

        if (load_pass) begin
            r_out.sample_out_i  <= i_entry.si;
            r_out.sample_out_q  <= i_entry.sq;
            r_out.measure_valid <= 1'b0;
            r_out.power_db      <= '0;
            r_out.snr_db        <= '0;
            r_out.snr_invalid   <= 1'b0;
        end else if (load_meas) begin
            r_out.sample_out_i  <= r_ent.si;
            r_out.sample_out_q  <= r_ent.sq;
            r_out.measure_valid <= 1'b1;
            r_out.power_db      <= q_zero ? DB_MIN : r_pdb;
            if (q_low) begin
                r_out.snr_db      <= DB_MIN;
                r_out.snr_invalid <= 1'b1;
            end else begin
                r_out.snr_db      <= n_zero ? DB_MAX : r_sdb;
                r_out.snr_invalid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/block_power_snr_meter_core.sv */
// block power and snr meter
// input channel: i_push/o_full with i_sample_i, i_sample_q, i_last; an item is
// taken when i_push is high and o_full is low
// result channel: o_empty/i_pop; the oldest result sits on the o_ ports while
// o_empty is low and leaves when i_pop is high
// configuration: i_cfg_valid/o_cfg_ready with i_cfg_data writes the noise floor;
// ready is always high
// every item gives exactly one result carrying the sample through unchanged
// a sample that does not close a window is written into the four-entry queue when
// it is taken and then moves into the registered result slot, so plain samples flow
// at one per cycle while the engine is idle and the result slot is free or popped
// a sample that closes a window of two or more samples holds the measurement
// engine for restoring division, bit-serial log2 of the power, the power less the
// noise floor and the noise floor, and dB scaling of power and snr; the queue
// keeps accepting up to four samples meanwhile
// reset clears the accumulator, the queue and the result slot, and sets the
// noise floor to 8
// a stalled receiver backs up through the result slot and the queue to o_full
module block_power_snr_meter_core
    import bpsm_pkg::*;
#(
    parameter int MAX_WINDOW = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [15:0] i_sample_i,
    input  logic signed [15:0] i_sample_q,
    input  logic               i_last,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [15:0] o_sample_out_i,
    output logic signed [15:0] o_sample_out_q,
    output logic               o_measure_valid,
    output logic signed [15:0] o_power_db,
    output logic signed [15:0] o_snr_db,
    output logic               o_snr_invalid,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    logic [15:0] r_noise_power;
    t_entry      fe_entry, q_entry;
    logic        q_empty, q_pop, accept;
    t_result     res;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_power <= NOISE_RST;
        end else if (i_cfg_valid) begin
            r_noise_power <= i_cfg_data;
        end
    end

    bpsm_front #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_sample_i (i_sample_i),
        .i_sample_q (i_sample_q),
        .i_last     (i_last),
        .o_entry    (fe_entry)
    );

    bpsm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (fe_entry),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_data  (q_entry),
        .o_empty (q_empty)
    );

    bpsm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (q_entry),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .i_noise  (r_noise_power),
        .o_result (res),
        .o_empty  (o_empty),
        .i_pop    (i_pop)
    );

    assign o_sample_out_i  = res.sample_out_i;
    assign o_sample_out_q  = res.sample_out_q;
    assign o_measure_valid = res.measure_valid;
    assign o_power_db      = res.power_db;
    assign o_snr_db        = res.snr_db;
    assign o_snr_invalid   = res.snr_invalid;

endmodule
